// ===== rtl/w6sv_pkg.sv =====
// Shared constants and types for the wheel-6 segmented prime sieve.
`timescale 1ns / 1ps
package w6sv_pkg;

	localparam int unsigned SEG_W    = 21;
	localparam int unsigned LIMIT_W  = 32;
	localparam int unsigned FLAG_W   = 64;
	localparam int unsigned OFFSET_W = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000000;
	// ceil(2^33 / 3): exact divide-by-3 for any 32-bit value
	localparam logic [LIMIT_W-1:0] RECIP3 = 32'hAAAAAAAB;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_LIM  = 12'b000000000010,
		S_LIMF = 12'b000000000100,
		S_CLR  = 12'b000000001000,
		S_SQ   = 12'b000000010000,
		S_IDX  = 12'b000000100000,
		S_ALN  = 12'b000001000000,
		S_DIV  = 12'b000010000000,
		S_MRD  = 12'b000100000000,
		S_MWR  = 12'b001000000000,
		S_ERD  = 12'b010000000000,
		S_ELD  = 12'b100000000000
	} state_t;

endpackage

// ===== rtl/wheel6_segment_prime_sieve.sv =====
// Top level of the wheel-6 segmented prime sieve.
// Takes one segment number, sieves SEGMENT_INDICES wheel indices (numbers 6k+-1 from 5 up)
// and returns ceil(SEGMENT_INDICES/64) flag words, one segment at a time. Each item starts
// with setup and clearing. Each sieving candidate p whose square has its index below the
// segment end then gets two runs; a run that starts below the segment first aligns through
// the bit-serial remainder unit, and each mark is a read-modify-write on the mark store.
// The closing candidate ends the sieving, then the flag words go out one by one while the
// output is not stalled. The remainder unit dominates for high segments.
// upper_limit is written only while idle (cfg_ready high).
`timescale 1ns / 1ps
module wheel6_segment_prime_sieve #(
	parameter int unsigned SEGMENT_INDICES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [w6sv_pkg::LIMIT_W-1:0]  upper_limit,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [w6sv_pkg::SEG_W-1:0]    segment_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [w6sv_pkg::OFFSET_W-1:0] word_offset,
	output logic [w6sv_pkg::FLAG_W-1:0]   prime_flags,
	output logic                          last_word
);

	localparam int unsigned N         = SEGMENT_INDICES;
	localparam int unsigned SEG_WORDS = (N + 63) / 64;
	localparam int unsigned AW        = (SEG_WORDS > 1) ? $clog2(SEG_WORDS) : 1;
	localparam int unsigned OW        = $clog2(N);
	localparam int unsigned IW        = w6sv_pkg::SEG_W + OW + 1;
	localparam int unsigned JW        = IW + 2;
	localparam int unsigned KW        = (IW + 1) / 2;
	localparam int unsigned SW        = KW + 4;
	localparam int unsigned LW        = w6sv_pkg::LIMIT_W;

	w6sv_pkg::state_t state_q;

	logic [LW-1:0]     limit_q;
	logic [JW-1:0]     base_q;
	logic [JW-1:0]     end_q;
	logic [KW-1:0]     k_q;
	logic              par_q;
	logic              run_q;
	logic [2*KW-1:0]   ksq_q;
	logic [JW-1:0]     j_q;
	logic [JW-1:0]     j1_q;
	logic [SW-1:0]     step_q;
	logic [AW-1:0]     w_q;
	logic [AW-1:0]     addr_q;
	logic [5:0]        bit_q;
	logic [LW-1:0]     x_q;
	logic [2*LW-1:0]   prod_q;
	logic [LW-1:0]     cnt_q;
	logic [6:0]        avail_q;

	logic                                   out_valid_q;
	logic [w6sv_pkg::OFFSET_W-1:0]          word_offset_q;
	logic [w6sv_pkg::FLAG_W-1:0]            prime_flags_q;
	logic                                   last_word_q;

	// memory and remainder unit hookup
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [w6sv_pkg::FLAG_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [w6sv_pkg::FLAG_W-1:0] mem_rdata;
	logic                        div_start;
	logic                        div_done;
	logic [SW-1:0]               div_rem;

	// combinational helpers
	logic [JW-1:0] ksq12, kj, j0_c, j1_c, off_c, lo_c, nw_c, a_c;
	logic [SW-1:0] step_c;
	logic [LW-2:0] m_c;
	logic [LW-1:0] r_c;
	logic          emit_go;
	logic [w6sv_pkg::FLAG_W-1:0] mask_c;

	assign ksq12 = (JW'(ksq_q) << 3) + (JW'(ksq_q) << 2);
	assign kj    = JW'(k_q);

	always_comb begin
		if (par_q) begin
			j0_c   = ksq12 + kj * JW'(28) + JW'(15);
			j1_c   = ksq12 + kj * JW'(36) + JW'(24);
			step_c = SW'(k_q) * SW'(12) + SW'(14);
		end else begin
			j0_c   = ksq12 + kj * JW'(20) + JW'(7);
			j1_c   = ksq12 + kj * JW'(24) + JW'(10);
			step_c = SW'(k_q) * SW'(12) + SW'(10);
		end
	end

	assign off_c = j_q - base_q;
	assign m_c   = prod_q[2*LW-1:LW+1];
	assign r_c   = x_q - ((LW'(m_c) << 1) + LW'(m_c));

	// count of usable bits in the word at w_q: limited by the upper limit and segment end
	always_comb begin
		lo_c = base_q + (JW'(w_q) << 6);
		nw_c = JW'(N) - (JW'(w_q) << 6);
		if (JW'(cnt_q) <= lo_c)
			a_c = '0;
		else
			a_c = JW'(cnt_q) - lo_c;
		if (nw_c < a_c)
			a_c = nw_c;
		if (a_c > JW'(64))
			a_c = JW'(64);
	end

	assign mask_c  = avail_q[6] ? '1 : ((64'd1 << avail_q[5:0]) - 64'd1);
	assign emit_go = !out_valid_q || !out_stall;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = mem_rdata | (64'd1 << bit_q);
		mem_re    = 1'b0;
		mem_raddr = off_c[AW+5:6];
		div_start = 1'b0;
		case (state_q)
			w6sv_pkg::S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = w_q;
				mem_wdata = '0;
			end
			w6sv_pkg::S_MRD: begin
				mem_re = (j_q < end_q);
			end
			w6sv_pkg::S_MWR: begin
				mem_we = 1'b1;
			end
			w6sv_pkg::S_ALN: begin
				div_start = (j_q < base_q);
			end
			w6sv_pkg::S_ERD: begin
				mem_re    = emit_go;
				mem_raddr = w_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= w6sv_pkg::S_IDLE;
			limit_q     <= w6sv_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			par_q       <= 1'b0;
			run_q       <= 1'b0;
			w_q         <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				w6sv_pkg::S_IDLE: begin
					if (cfg_valid)
						limit_q <= upper_limit;
					if (in_valid)
						state_q <= w6sv_pkg::S_LIM;
				end
				w6sv_pkg::S_LIM: begin
					state_q <= w6sv_pkg::S_LIMF;
				end
				w6sv_pkg::S_LIMF: begin
					w_q     <= '0;
					state_q <= w6sv_pkg::S_CLR;
				end
				w6sv_pkg::S_CLR: begin
					if (w_q == AW'(SEG_WORDS - 1)) begin
						w_q     <= '0;
						k_q     <= '0;
						par_q   <= 1'b0;
						run_q   <= 1'b0;
						state_q <= w6sv_pkg::S_SQ;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				w6sv_pkg::S_SQ: begin
					state_q <= w6sv_pkg::S_IDX;
				end
				w6sv_pkg::S_IDX: begin
					if (j0_c >= end_q)
						state_q <= w6sv_pkg::S_ERD;
					else
						state_q <= w6sv_pkg::S_ALN;
				end
				w6sv_pkg::S_ALN: begin
					if (j_q < base_q)
						state_q <= w6sv_pkg::S_DIV;
					else
						state_q <= w6sv_pkg::S_MRD;
				end
				w6sv_pkg::S_DIV: begin
					if (div_done)
						state_q <= w6sv_pkg::S_MRD;
				end
				w6sv_pkg::S_MRD: begin
					if (j_q < end_q) begin
						state_q <= w6sv_pkg::S_MWR;
					end else if (!run_q) begin
						run_q   <= 1'b1;
						state_q <= w6sv_pkg::S_ALN;
					end else begin
						run_q <= 1'b0;
						par_q <= !par_q;
						if (par_q)
							k_q <= k_q + 1'b1;
						state_q <= w6sv_pkg::S_SQ;
					end
				end
				w6sv_pkg::S_MWR: begin
					state_q <= w6sv_pkg::S_MRD;
				end
				w6sv_pkg::S_ERD: begin
					if (emit_go)
						state_q <= w6sv_pkg::S_ELD;
				end
				w6sv_pkg::S_ELD: begin
					out_valid_q <= 1'b1;
					if (w_q == AW'(SEG_WORDS - 1)) begin
						w_q     <= '0;
						state_q <= w6sv_pkg::S_IDLE;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= w6sv_pkg::S_ERD;
					end
				end
				default: begin
					state_q <= w6sv_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			w6sv_pkg::S_IDLE: begin
				base_q <= JW'(segment_number) * JW'(N);
			end
			w6sv_pkg::S_LIM: begin
				end_q  <= base_q + JW'(N);
				// limit taken here so a write at the accepting edge already applies
				x_q    <= limit_q - LW'(4);
				prod_q <= (2*LW)'(LW'(limit_q - LW'(4))) * (2*LW)'(w6sv_pkg::RECIP3);
			end
			w6sv_pkg::S_LIMF: begin
				if (limit_q < LW'(4))
					cnt_q <= '0;
				else if (m_c[0] || (r_c != '0))
					cnt_q <= LW'(m_c) + LW'(1);
				else
					cnt_q <= LW'(m_c);
			end
			w6sv_pkg::S_SQ: begin
				ksq_q <= (2*KW)'(k_q) * (2*KW)'(k_q);
			end
			w6sv_pkg::S_IDX: begin
				j_q    <= j0_c;
				j1_q   <= j1_c;
				step_q <= step_c;
			end
			w6sv_pkg::S_DIV: begin
				if (div_done) begin
					if (div_rem == '0)
						j_q <= base_q;
					else
						j_q <= base_q + JW'(step_q) - JW'(div_rem);
				end
			end
			w6sv_pkg::S_MRD: begin
				addr_q <= off_c[AW+5:6];
				bit_q  <= off_c[5:0];
				if (j_q >= end_q && !run_q)
					j_q <= j1_q;
			end
			w6sv_pkg::S_MWR: begin
				j_q <= j_q + JW'(step_q);
			end
			w6sv_pkg::S_ERD: begin
				avail_q <= 7'(a_c);
			end
			w6sv_pkg::S_ELD: begin
				word_offset_q <= w6sv_pkg::OFFSET_W'(w_q);
				prime_flags_q <= ~mem_rdata & mask_c;
				last_word_q   <= (w_q == AW'(SEG_WORDS - 1));
			end
			default: begin
			end
		endcase
	end

	w6sv_mark_mem #(
		.WORDS (SEG_WORDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	w6sv_rem #(
		.DVD_W (JW),
		.DVS_W (SW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (base_q - j_q),
		.divisor  (step_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign cfg_ready   = (state_q == w6sv_pkg::S_IDLE);
	assign in_stall    = (state_q != w6sv_pkg::S_IDLE);
	assign out_valid   = out_valid_q;
	assign word_offset = word_offset_q;
	assign prime_flags = prime_flags_q;
	assign last_word   = last_word_q;

endmodule

// ===== rtl/w6sv_rem.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module w6sv_rem #(
	parameter int unsigned DVD_W = 40,
	parameter int unsigned DVS_W = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVS_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;

	assign trial = {rem_q, dvd_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, divisor})
				rem_q <= DVS_W'(trial - {1'b0, divisor});
			else
				rem_q <= DVS_W'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/w6sv_mark_mem.sv =====
// Composite-mark store: one 64-bit word per 64 wheel indices, registered read.
`timescale 1ns / 1ps
module w6sv_mark_mem #(
	parameter int unsigned WORDS = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [w6sv_pkg::FLAG_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [w6sv_pkg::FLAG_W-1:0] rdata
);

	logic [w6sv_pkg::FLAG_W-1:0] mem [WORDS];
	logic [w6sv_pkg::FLAG_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/w6sv_chk.sv =====
// Port-level checker for the wheel-6 segmented prime sieve, bound to the top level.
`timescale 1ns / 1ps
module w6sv_chk #(
	parameter int unsigned SEGMENT_INDICES = 1024
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_ready,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [w6sv_pkg::OFFSET_W-1:0] word_offset,
	input logic [w6sv_pkg::FLAG_W-1:0]   prime_flags,
	input logic                          last_word
);

	localparam int unsigned SEG_WORDS = (SEGMENT_INDICES + 63) / 64;
	localparam logic [w6sv_pkg::OFFSET_W-1:0] LAST_OFF = w6sv_pkg::OFFSET_W'(SEG_WORDS - 1);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prime_flags) && $stable(word_offset))
		else $error("stalled output changed");

	// one segment at a time: an accepted item blocks the input next cycle
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !cfg_ready)
		else $error("input not blocked after accept");

	// config port open exactly when input is open
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall)
		else $error("config ready out of step with input");

	// the final word carries the last offset
	a_last_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_word |-> word_offset == LAST_OFF)
		else $error("last word at wrong offset");

endmodule

bind wheel6_segment_prime_sieve w6sv_chk #(
	.SEGMENT_INDICES (SEGMENT_INDICES)
) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_ready   (cfg_ready),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.word_offset (word_offset),
	.prime_flags (prime_flags),
	.last_word   (last_word)
);

// ===== verif/wheel6_segment_prime_sieve_tb.sv =====
// Self-checking testbench for the wheel-6 segmented prime sieve.
`timescale 1ns / 1ps

typedef struct {
	logic [w6sv_pkg::OFFSET_W-1:0] offset;
	logic [w6sv_pkg::FLAG_W-1:0]   flags;
	logic                          last;
} flag_word_t;

class sieve_scoreboard;
	localparam int unsigned SEG_IDX = 1024;
	localparam int unsigned N_WORDS = (SEG_IDX + 63) / 64;

	flag_word_t pending_words[$];
	logic [w6sv_pkg::LIMIT_W-1:0] limit_value = w6sv_pkg::LIMIT_RESET;
	longint unsigned composite[N_WORDS];
	int errors = 0;
	int words_checked = 0;

	function longint unsigned num_of(longint unsigned i);
		return (i & 1) ? 3 * i + 4 : 3 * i + 5;
	endfunction

	function longint unsigned idx_of(longint unsigned v);
		return (v % 6 == 5) ? (v - 5) / 3 : (v - 4) / 3;
	endfunction

	function void strike_run(longint unsigned v0, longint unsigned stride,
			longint unsigned base, longint unsigned seg_end);
		longint unsigned j;
		longint unsigned off;
		j = idx_of(v0);
		if (j < base)
			j += ((base - j + stride - 1) / stride) * stride;
		for (; j < seg_end; j += stride) begin
			off = j - base;
			if (off < SEG_IDX)
				composite[off >> 6] |= 64'd1 << (off & 63);
		end
	endfunction

	// Sieve one segment at the current limit and queue its flag words.
	function void note_segment(logic [w6sv_pkg::SEG_W-1:0] seg);
		longint unsigned base, seg_end, p, s, off;
		logic [63:0] f;
		flag_word_t w;
		base = longint'(seg) * SEG_IDX;
		seg_end = base + SEG_IDX;
		foreach (composite[k]) composite[k] = 0;
		s = 0;
		p = num_of(s);
		while (idx_of(p * p) < seg_end) begin
			strike_run(p * p, 2 * p, base, seg_end);
			strike_run(p * (p + ((p % 6 == 5) ? 2 : 4)), 2 * p, base, seg_end);
			s++;
			p = num_of(s);
		end
		for (int k = 0; k < N_WORDS; k++) begin
			f = ~composite[k];
			for (int b = 0; b < 64; b++) begin
				off = k * 64 + b;
				if (off >= SEG_IDX || num_of(base + off) > longint'(limit_value))
					f[b] = 1'b0;
			end
			w.offset = k[3:0];
			w.flags = f;
			w.last = (k == N_WORDS - 1);
			pending_words = {pending_words, w};
		end
	endfunction

	function void check_word(logic [3:0] offset, logic [63:0] flags, logic last);
		flag_word_t e;
		words_checked++;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected word offset=%0d flags=%h last=%b",
				$time, offset, flags, last);
			errors++;
			return;
		end
		e = pending_words.pop_front();
		if (offset !== e.offset) begin
			$display("%0t: word_offset expected %0d actual %0d", $time, e.offset, offset);
			errors++;
		end
		if (flags !== e.flags) begin
			$display("%0t: prime_flags expected %h actual %h", $time, e.flags, flags);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: last_word expected %b actual %b", $time, e.last, last);
			errors++;
		end
	endfunction
endclass

module wheel6_segment_prime_sieve_tb;

	localparam longint CYCLE_LIMIT = 40_000_000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [w6sv_pkg::LIMIT_W-1:0]  upper_limit = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [w6sv_pkg::SEG_W-1:0]    segment_number = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [w6sv_pkg::OFFSET_W-1:0] word_offset;
	logic [w6sv_pkg::FLAG_W-1:0]   prime_flags;
	logic                          last_word;

	sieve_scoreboard sb = new();
	longint cycle_count = 0;
	int segments_sent = 0;
	int stall_mode = 0;
	int long_hold_req = 0;
	int hold_left = 0;

	wheel6_segment_prime_sieve uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("wheel6_segment_prime_sieve_tb: FAIL");
			$finish;
		end
	end

	// Result side: check each transaction, stall on its own pattern.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_word(word_offset, prime_flags, last_word);
		if (long_hold_req > 0 && hold_left == 0) begin
			hold_left = long_hold_req;
			long_hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				1: out_stall <= ($urandom_range(0, 99) < 35);
				2: out_stall <= (cycle_count % 7 < 3);
				3: out_stall <= ($urandom_range(0, 99) < 85);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic send_segment(input logic [w6sv_pkg::SEG_W-1:0] seg, input int gap);
		in_valid <= 1'b1;
		segment_number <= seg;
		do @(posedge clk); while (in_stall);
		sb.note_segment(seg);
		segments_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		// stop offering so the idle block does not take the last segment again
		in_valid <= 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(input logic [w6sv_pkg::LIMIT_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		upper_limit <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.limit_value = value;
	endtask

	function automatic logic [w6sv_pkg::SEG_W-1:0] pick_segment();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return w6sv_pkg::SEG_W'($urandom_range(0, 12));
		if (r < 98) return w6sv_pkg::SEG_W'($urandom_range(13, 300));
		return w6sv_pkg::SEG_W'($urandom_range(301, 4095));
	endfunction

	task automatic random_phase(input int n_items);
		int burst;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 6);
			for (int k = 0; k < burst && sent < n_items; k++) begin
				sent++;
				send_segment(pick_segment(),
					(k == burst - 1) ? $urandom_range(1, 40) : 0);
			end
			if ($urandom_range(0, 9) == 0)
				stall_mode = $urandom_range(0, 3);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limit, the smallest segment holds 5 and 7
		send_segment(0, 0);
		send_segment(1, 0);
		send_segment(2, 3);
		send_segment(7, 0);
		write_limit(32'd0);
		send_segment(0, 0);
		send_segment(5, 2);
		// limit falls inside segment 0
		write_limit(32'd3000);
		stall_mode = 1;
		send_segment(0, 0);
		send_segment(1, 1);
		write_limit(32'hFFFF_FFFF);
		send_segment(0, 0);
		send_segment(4095, 0);
		send_segment(21'h1F_FFFF, 0);
		send_segment(1000, 5);

		// receiver holds off for a long stretch while items keep coming
		write_limit(32'd1_000_000);
		stall_mode = 2;
		long_hold_req = 4000;
		random_phase(90);

		write_limit($urandom_range(0, 40000));
		stall_mode = 0;
		random_phase(90);

		write_limit($urandom());
		stall_mode = 3;
		random_phase(90);

		drain();
		repeat (100) @(posedge clk);
		$display("Sieved %0d segments under limits of 0, 3000, the reset value, max and random,",
			segments_sent);
		$display("checked %0d flag words with bursty input and varied output stalls.",
			sb.words_checked);
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("wheel6_segment_prime_sieve_tb: PASS");
		else
			$display("wheel6_segment_prime_sieve_tb: FAIL");
		$finish;
	end
endmodule
